// ===== design/tpfr_pkg.sv =====
// ----------------------------------------------------------------------------
// tpfr_pkg
// Shared types and constants of the timestamp-paced frame replay block.
// ----------------------------------------------------------------------------
package tpfr_pkg;

    // Command codes carried in the input item.
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_APPEND = 3'd1;
    localparam logic [2:0] CMD_CLEAR  = 3'd2;
    localparam logic [2:0] CMD_PLAY   = 3'd3;
    localparam logic [2:0] CMD_PAUSE  = 3'd4;
    localparam logic [2:0] CMD_STOP   = 3'd5;
    localparam logic [2:0] CMD_REWIND = 3'd6;
    localparam logic [2:0] CMD_SPEED  = 3'd7;

    // Result kinds.
    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Width of the position and frame count status fields.
    localparam int unsigned POS_W = 11;

    // Largest payload byte count kept in the store.
    localparam logic [3:0] MAX_LENGTH = 4'd8;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] tick_delta;
        logic [63:0] in_timestamp;
        logic [28:0] in_ident;
        logic        in_extended;
        logic [3:0]  in_length;
        logic [63:0] in_payload;
    } tpfr_in_t;

    typedef struct packed {
        logic             kind;
        logic             last;
        logic [63:0]      out_timestamp;
        logic [28:0]      out_ident;
        logic             out_extended;
        logic [3:0]       out_length;
        logic [63:0]      out_payload;
        logic             is_playing;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] frame_count;
        logic [1:0]       speed_shift;
        logic             append_rejected;
    } tpfr_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;       // input transfer taken this cycle
        logic add;          // advance the elapsed counter, clear the burst count
        logic rd_en;        // read the store at the current position
        logic release_frame;// load the read frame into the output register
        logic finish;       // end-of-tick handling: loop or stop at end of store
        logic send_status;  // load the closing status into the output register
    } tpfr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic tick_start;   // incoming item is a tick that has work to do
        logic eligible;     // the read frame is due and within the burst limit
        logic out_free;     // output register can take a result this cycle
    } tpfr_sts_t;

endpackage

// ===== design/tpfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpfr_ctrl
// Controller state machine: sequences item acceptance, the per-frame read
// and release loop of a tick, and the closing status.
// ----------------------------------------------------------------------------
module tpfr_ctrl
    import tpfr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  tpfr_sts_t sts,
    output tpfr_cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_ADD    = 6'b000010,
        ST_READ   = 6'b000100,
        ST_CHECK  = 6'b001000,
        ST_FINISH = 6'b010000,
        ST_STATUS = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = sts.tick_start ? ST_ADD : ST_STATUS;
                end
            end
            ST_ADD: begin
                cmd.add    = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (!sts.eligible) begin
                    state_next = ST_FINISH;
                end else if (sts.out_free) begin
                    cmd.release_frame = 1'b1;
                    state_next        = ST_READ;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_STATUS;
            end
            ST_STATUS: begin
                if (sts.out_free) begin
                    cmd.send_status = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/tpfr_datapath.sv =====
// ----------------------------------------------------------------------------
// tpfr_datapath
// Frame store, replay registers, elapsed-time arithmetic and the output
// register of the timestamp-paced frame replay block.
// ----------------------------------------------------------------------------
module tpfr_datapath
    import tpfr_pkg::*;
#(
    parameter int unsigned STORE_DEPTH = 1024,
    parameter int unsigned MAX_BURST   = 63
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  tpfr_in_t  s_data,
    input  logic      cfg_valid,
    input  logic      cfg_data,
    output logic      m_valid,
    input  logic      m_ready,
    output tpfr_out_t m_data,
    input  tpfr_cmd_t cmd,
    output tpfr_sts_t sts
);

    localparam int unsigned ADDR_W  = $clog2(STORE_DEPTH);
    localparam int unsigned CNT_W   = $clog2(STORE_DEPTH + 1);
    localparam int unsigned BURST_W = $clog2(MAX_BURST + 1);
    localparam int unsigned WIDE_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    // One store entry. rel holds the timestamp less the first frame's
    // timestamp, worked out once when the frame is appended.
    typedef struct packed {
        logic [63:0] rel;
        logic [63:0] stamp;
        logic [28:0] ident;
        logic        extended;
        logic [3:0]  length;
        logic [63:0] payload;
    } entry_t;

    entry_t store_mem [STORE_DEPTH];
    entry_t rd_reg;
    entry_t wr_entry;
    logic   mem_we;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   index_reg, index_next;
    logic [63:0]        elapsed_reg, elapsed_next;
    logic [63:0]        base_reg, base_next;
    logic [1:0]         speed_reg, speed_next;
    logic               running_reg, running_next;
    logic               loop_reg;
    logic               rejected_reg, rejected_next;
    logic [31:0]        delta_reg;
    logic [BURST_W-1:0] burst_reg, burst_next;
    logic               m_valid_reg;
    tpfr_out_t          m_data_reg;
    tpfr_out_t          frame_res;
    tpfr_out_t          status_res;

    logic               full;
    logic [35:0]        add_amount;
    logic [64:0]        sum;
    logic [WIDE_W-1:0]  index_wide;
    logic [WIDE_W-1:0]  count_wide;

    assign full       = (count_reg == CNT_W'(STORE_DEPTH));
    assign add_amount = {4'd0, delta_reg} << speed_reg;
    assign sum        = {1'b0, elapsed_reg} + {29'd0, add_amount};
    assign index_wide = WIDE_W'(index_reg);
    assign count_wide = WIDE_W'(count_reg);

    assign sts.tick_start = (s_data.command == CMD_TICK) && running_reg &&
                            (count_reg != '0);
    assign sts.eligible   = (index_reg < count_reg) &&
                            (burst_reg < BURST_W'(MAX_BURST)) &&
                            (rd_reg.rel <= elapsed_reg);
    assign sts.out_free   = !m_valid_reg || m_ready;

    always_comb begin
        count_next    = count_reg;
        index_next    = index_reg;
        elapsed_next  = elapsed_reg;
        base_next     = base_reg;
        speed_next    = speed_reg;
        running_next  = running_reg;
        rejected_next = rejected_reg;
        burst_next    = burst_reg;
        mem_we        = 1'b0;

        wr_entry.stamp    = s_data.in_timestamp;
        wr_entry.ident    = s_data.in_ident;
        wr_entry.extended = s_data.in_extended;
        wr_entry.length   = (s_data.in_length > MAX_LENGTH) ? MAX_LENGTH :
                                                              s_data.in_length;
        wr_entry.payload  = s_data.in_payload;
        wr_entry.rel      = (count_reg == '0) ? 64'd0 :
                                                s_data.in_timestamp - base_reg;

        if (cmd.accept) begin
            rejected_next = 1'b0;
            unique case (s_data.command)
                CMD_TICK: begin
                end
                CMD_APPEND: begin
                    if (full) begin
                        rejected_next = 1'b1;
                    end else begin
                        mem_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (count_reg == '0) begin
                            base_next = s_data.in_timestamp;
                        end
                    end
                end
                CMD_CLEAR: begin
                    count_next   = '0;
                    running_next = 1'b0;
                    index_next   = '0;
                    elapsed_next = '0;
                    speed_next   = '0;
                end
                CMD_PLAY: begin
                    if (count_reg != '0) begin
                        running_next = 1'b1;
                    end
                end
                CMD_PAUSE: begin
                    running_next = 1'b0;
                end
                CMD_STOP: begin
                    running_next = 1'b0;
                    index_next   = '0;
                    elapsed_next = '0;
                    speed_next   = '0;
                end
                CMD_REWIND: begin
                    index_next   = '0;
                    elapsed_next = '0;
                end
                CMD_SPEED: begin
                    speed_next = speed_reg + 2'd1;
                end
                default: begin
                end
            endcase
        end

        if (cmd.add) begin
            elapsed_next = sum[64] ? {64{1'b1}} : sum[63:0];
            burst_next   = '0;
        end

        if (cmd.release_frame) begin
            index_next = index_reg + 1'b1;
            burst_next = burst_reg + 1'b1;
        end

        if (cmd.finish && (index_reg >= count_reg)) begin
            if (loop_reg) begin
                index_next   = '0;
                elapsed_next = '0;
            end else begin
                running_next = 1'b0;
            end
        end
    end

    // Result words for a released frame and for the closing status.
    always_comb begin
        frame_res               = '0;
        frame_res.kind          = KIND_FRAME;
        frame_res.last          = 1'b0;
        frame_res.out_timestamp = rd_reg.stamp;
        frame_res.out_ident     = rd_reg.ident;
        frame_res.out_extended  = rd_reg.extended;
        frame_res.out_length    = rd_reg.length;
        frame_res.out_payload   = rd_reg.payload;

        status_res                 = '0;
        status_res.kind            = KIND_STATUS;
        status_res.last            = 1'b1;
        status_res.is_playing      = running_reg;
        status_res.position        = index_wide[POS_W-1:0];
        status_res.frame_count     = count_wide[POS_W-1:0];
        status_res.speed_shift     = speed_reg;
        status_res.append_rejected = rejected_reg;
    end

    // Store write and registered read.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[count_reg[ADDR_W-1:0]] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_reg <= store_mem[index_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            index_reg    <= '0;
            elapsed_reg  <= '0;
            speed_reg    <= '0;
            running_reg  <= 1'b0;
            loop_reg     <= 1'b0;
            rejected_reg <= 1'b0;
            burst_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            count_reg    <= count_next;
            index_reg    <= index_next;
            elapsed_reg  <= elapsed_next;
            speed_reg    <= speed_next;
            running_reg  <= running_next;
            rejected_reg <= rejected_next;
            burst_reg    <= burst_next;
            if (cfg_valid) begin
                loop_reg <= cfg_data;
            end
            if (cmd.release_frame || cmd.send_status) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        base_reg <= base_next;
        if (cmd.accept) begin
            delta_reg <= s_data.tick_delta;
        end
        if (cmd.release_frame) begin
            m_data_reg <= frame_res;
        end else if (cmd.send_status) begin
            m_data_reg <= status_res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== design/timestamp_paced_frame_replay.sv =====
// ----------------------------------------------------------------------------
// timestamp_paced_frame_replay
// Stores captured bus frames with their timestamps and replays them paced by
// an elapsed-time counter that ticks advance at 1x, 2x, 4x or 8x speed.
// ----------------------------------------------------------------------------
//
// Channel   Ports                          Direction  Carries
// s_        s_valid, s_ready, s_data       in         one command item
// m_        m_valid, m_ready, m_data       out        released frames, then status
// cfg_      cfg_valid, cfg_ready, cfg_data in         loop_enable register
//
// A command other than a tick, or a tick with nothing to do, goes through
// the transfer in, then the closing status loaded into the output register.
// A tick that has work goes through the transfer in, the elapsed update, a
// store read and a due check for each released frame plus one more pair for
// the frame that ends the burst, the end-of-store step and the closing status.
// The frame store has a single read port and registered read data, so each
// frame is read in one step and checked in the next. Reset is synchronous
// and active low; the store contents are not cleared, only the counters. A
// stalled result channel holds the block in place without losing anything.
//
module timestamp_paced_frame_replay
    import tpfr_pkg::*;
#(
    parameter int unsigned STORE_DEPTH = 1024,
    parameter int unsigned MAX_BURST   = 63
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  tpfr_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output tpfr_out_t m_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    tpfr_cmd_t cmd;
    tpfr_sts_t sts;

    // The loop register is a single flop, so every configuration transfer is
    // taken at once.
    assign cfg_ready = 1'b1;

    // The controller walks each item through acceptance, the read and release
    // loop of a tick, and the closing status. All replay state lives in the
    // datapath.
    tpfr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath holds the frame store, the elapsed counter with its
    // saturating add, the due-frame compare and the output register, which
    // lets the controller keep working while a result waits to be taken.
    tpfr_datapath #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_BURST   (MAX_BURST)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ===== verif/tpfr_replay_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tpfr_replay_checker
// Watches the command, result and register channels of the frame replay
// block, keeps its own copy of the store and replay state, and compares
// every result transfer field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module tpfr_replay_checker
    import tpfr_pkg::*;
#(
    parameter int unsigned STORE_DEPTH  = 1024,
    parameter int unsigned MAX_BURST    = 63,
    parameter int unsigned REPORT_LIMIT = 40
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  tpfr_in_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  tpfr_out_t   m_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    output int unsigned fail_count,
    output int unsigned outstanding,
    output int unsigned frames_seen
);

    // Replay state as the block should hold it.
    logic [63:0]      stamps   [STORE_DEPTH];
    logic [29:0]      idents   [STORE_DEPTH];
    logic [67:0]      payloads [STORE_DEPTH];
    logic [POS_W-1:0] frames_held;
    logic [POS_W-1:0] play_pos;
    logic [63:0]      elapsed_us;
    logic [1:0]       speed_exp;
    logic             playing;
    logic             loop_on;

    tpfr_out_t   results_due [$];
    int unsigned errors;
    int unsigned frame_total;

    task automatic stop_replay();
        playing    = 1'b0;
        play_pos   = '0;
        elapsed_us = '0;
        speed_exp  = '0;
    endtask

    // Works out every result that one command causes and queues them in order.
    task automatic apply_command(input tpfr_in_t cmd_in);
        tpfr_out_t   res;
        logic        rejected;
        logic [63:0] step_us;
        logic [63:0] lag_us;
        logic [3:0]  len_kept;
        int unsigned burst;
        rejected = 1'b0;
        case (cmd_in.command)
            CMD_TICK: begin
                if (playing && frames_held != 0) begin
                    step_us = {32'd0, cmd_in.tick_delta} << speed_exp;
                    // ~step_us is the headroom left below the ceiling.
                    if (elapsed_us > ~step_us) begin
                        elapsed_us = '1;
                    end else begin
                        elapsed_us = elapsed_us + step_us;
                    end
                    burst = 0;
                    while (play_pos < frames_held && burst < MAX_BURST) begin
                        lag_us = stamps[play_pos] - stamps[0];
                        if (lag_us > elapsed_us) break;
                        res = '0;
                        res.kind = KIND_FRAME;
                        res.out_timestamp = stamps[play_pos];
                        {res.out_extended, res.out_ident} = idents[play_pos];
                        {res.out_length, res.out_payload} = payloads[play_pos];
                        results_due = {results_due, res};
                        burst++;
                        play_pos++;
                    end
                    if (play_pos >= frames_held) begin
                        if (loop_on) begin
                            play_pos   = '0;
                            elapsed_us = '0;
                        end else begin
                            playing = 1'b0;
                        end
                    end
                end
            end
            CMD_APPEND: begin
                if (frames_held >= STORE_DEPTH) begin
                    rejected = 1'b1;
                end else begin
                    len_kept = (cmd_in.in_length > MAX_LENGTH) ? MAX_LENGTH
                                                               : cmd_in.in_length;
                    stamps[frames_held]   = cmd_in.in_timestamp;
                    idents[frames_held]   = {cmd_in.in_extended, cmd_in.in_ident};
                    payloads[frames_held] = {len_kept, cmd_in.in_payload};
                    frames_held++;
                end
            end
            CMD_CLEAR: begin
                frames_held = '0;
                stop_replay();
            end
            CMD_PLAY: begin
                if (frames_held != 0) playing = 1'b1;
            end
            CMD_PAUSE: begin
                playing = 1'b0;
            end
            CMD_STOP: begin
                stop_replay();
            end
            CMD_REWIND: begin
                play_pos   = '0;
                elapsed_us = '0;
            end
            CMD_SPEED: begin
                speed_exp = speed_exp + 2'd1;
            end
        endcase
        res = '0;
        res.kind            = KIND_STATUS;
        res.last            = 1'b1;
        res.is_playing      = playing;
        res.position        = play_pos;
        res.frame_count     = frames_held;
        res.speed_shift     = speed_exp;
        res.append_rejected = rejected;
        results_due = {results_due, res};
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
                $display("%0t ns: %s mismatch, expected %h, actual %h",
                         $time, field, want, got);
            end
        end
    endtask

    always @(posedge aclk) begin
        tpfr_out_t want;
        if (!aresetn) begin
            frames_held = '0;
            loop_on     = 1'b0;
            stop_replay();
            results_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) loop_on = cfg_data;
            // Results leave only after their command has been taken, so the
            // comparison is made before this cycle's command is predicted.
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_LIMIT) begin
                        $display("%0t ns: unexpected result, expected none, actual %h",
                                 $time, m_data);
                    end
                end else begin
                    want = results_due.pop_front();
                    if (want.kind == KIND_FRAME) frame_total++;
                    check_field("kind", 64'(want.kind), 64'(m_data.kind));
                    check_field("last", 64'(want.last), 64'(m_data.last));
                    check_field("out_timestamp", want.out_timestamp,
                                m_data.out_timestamp);
                    check_field("out_ident", 64'(want.out_ident),
                                64'(m_data.out_ident));
                    check_field("out_extended", 64'(want.out_extended),
                                64'(m_data.out_extended));
                    check_field("out_length", 64'(want.out_length),
                                64'(m_data.out_length));
                    check_field("out_payload", want.out_payload, m_data.out_payload);
                    check_field("is_playing", 64'(want.is_playing),
                                64'(m_data.is_playing));
                    check_field("position", 64'(want.position), 64'(m_data.position));
                    check_field("frame_count", 64'(want.frame_count),
                                64'(m_data.frame_count));
                    check_field("speed_shift", 64'(want.speed_shift),
                                64'(m_data.speed_shift));
                    check_field("append_rejected", 64'(want.append_rejected),
                                64'(m_data.append_rejected));
                end
            end
            if (s_valid && s_ready) apply_command(s_data);
        end
        fail_count  <= errors;
        outstanding <= results_due.size();
        frames_seen <= frame_total;
    end

endmodule

// ===== verif/tb_timestamp_paced_frame_replay.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timestamp_paced_frame_replay
// Drives command items and loop register writes into the frame replay block
// under several idle and back-pressure patterns, and gives the verdict from
// the failure count that the checker alongside the block reports.
// ----------------------------------------------------------------------------
module tb_timestamp_paced_frame_replay;
    import tpfr_pkg::*;

    localparam int unsigned DEPTH       = 1024;
    localparam int unsigned BURST       = 63;
    // Far beyond the slowest legal run, including the long receiver hold-off.
    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int unsigned LONG_HOLD   = 600;
    // Quiet cycles allowed after the last result before the block is idle.
    localparam int unsigned SETTLE      = 20;
    // Frames sharing one stamp, more than a single tick may release.
    localparam int unsigned BURST_FILL  = 70;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    tpfr_in_t  s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    tpfr_out_t m_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data  = 1'b0;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_req       = 0;
    int unsigned hold_ack       = 0;
    int unsigned hold_left      = 0;
    int unsigned cycles         = 0;
    int unsigned items_sent     = 0;
    // The testbench's own idea of the store fill, used only to shape stimulus.
    int unsigned frames_in_store = 0;
    logic [63:0] next_stamp      = '0;

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned frames_seen;

    always #4 aclk = ~aclk;

    timestamp_paced_frame_replay #(
        .STORE_DEPTH (DEPTH),
        .MAX_BURST   (BURST)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    tpfr_replay_checker #(
        .STORE_DEPTH (DEPTH),
        .MAX_BURST   (BURST)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .frames_seen (frames_seen)
    );

    // Result receiver. A change of hold_req starts a long hold-off, counted
    // here, during which no result transfer can complete; otherwise ready is
    // dropped at random at the current stall rate.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= LONG_HOLD;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycles, outstanding);
            $display("FAILURE");
            $finish;
        end
    end

    // An item with every field random; callers override what matters.
    function automatic tpfr_in_t any_item(input logic [2:0] cmd);
        tpfr_in_t it;
        it.command      = cmd;
        it.tick_delta   = $urandom;
        it.in_timestamp = {$urandom, $urandom};
        it.in_ident     = 29'($urandom);
        it.in_extended  = 1'($urandom);
        it.in_length    = 4'($urandom);
        it.in_payload   = {$urandom, $urandom};
        return it;
    endfunction

    function automatic tpfr_in_t tick_item(input logic [31:0] delta);
        tpfr_in_t it;
        it            = any_item(CMD_TICK);
        it.tick_delta = delta;
        return it;
    endfunction

    function automatic tpfr_in_t frame_item(input logic [63:0] stamp,
                                            input logic [28:0] ident,
                                            input logic        ext,
                                            input logic [3:0]  len,
                                            input logic [63:0] payload);
        tpfr_in_t it;
        it              = any_item(CMD_APPEND);
        it.in_timestamp = stamp;
        it.in_ident     = ident;
        it.in_extended  = ext;
        it.in_length    = len;
        it.in_payload   = payload;
        return it;
    endfunction

    task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // Offers one item and returns at the edge where it is transferred. Valid
    // is only lowered when a gap is to follow, so back-to-back items keep it
    // high without a second assignment in the same time step.
    task automatic send_item(input tpfr_in_t it);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (it.command == CMD_APPEND && frames_in_store < DEPTH) frames_in_store++;
        if (it.command == CMD_CLEAR) frames_in_store = 0;
    endtask

    // The sender pauses until every predicted result has been taken, then
    // waits out the SETTLE quiet period.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_loop(input logic on);
        cfg_valid <= 1'b1;
        cfg_data  <= on;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Frame stamps mostly climb in small steps from a random start, so that
    // ticks release a few frames each; now and then a wild stamp appears,
    // which may fall before the first frame and so hold replay back.
    task automatic send_frame();
        tpfr_in_t it;
        it = any_item(CMD_APPEND);
        if (frames_in_store == 0 || $urandom_range(29) == 0) begin
            next_stamp = {$urandom, $urandom};
        end else begin
            next_stamp = next_stamp + $urandom_range(400);
        end
        it.in_timestamp = next_stamp;
        send_item(it);
    endtask

    task automatic send_tick();
        if ($urandom_range(19) == 0) begin
            send_item(tick_item($urandom));
        end else begin
            send_item(tick_item($urandom_range(300)));
        end
    endtask

    task automatic send_control();
        case ($urandom_range(6))
            0:       send_item(any_item(CMD_PAUSE));
            1:       send_item(any_item(CMD_PLAY));
            2:       send_item(any_item(CMD_REWIND));
            3, 4:    send_item(any_item(CMD_SPEED));
            5:       send_item(any_item(CMD_STOP));
            default: send_item(any_item(CMD_CLEAR));
        endcase
    endtask

    // Mostly well-formed episodes: an optional clear, a handful of frames,
    // play, then a run of ticks with the odd control command mixed in. About
    // one episode in ten is replaced by a single item of random content.
    task automatic random_phase(input int unsigned quota);
        int unsigned start_count;
        int unsigned n_frames;
        int unsigned n_ticks;
        int unsigned k;
        tpfr_in_t    it;
        start_count = items_sent;
        while (items_sent - start_count < quota) begin
            if ($urandom_range(9) == 0) begin
                it = any_item(3'($urandom_range(7)));
                if (it.command == CMD_TICK && $urandom_range(3) != 0) begin
                    it.tick_delta = $urandom_range(2000);
                end
                send_item(it);
            end else begin
                if (frames_in_store > 150 || $urandom_range(3) == 0) begin
                    send_item(any_item(CMD_CLEAR));
                end
                n_frames = $urandom_range(12, 1);
                for (k = 0; k < n_frames; k++) send_frame();
                send_item(any_item(CMD_PLAY));
                n_ticks = $urandom_range(10, 2);
                for (k = 0; k < n_ticks; k++) begin
                    if ($urandom_range(99) < 15) send_control();
                    send_tick();
                end
            end
        end
    endtask

    initial begin
        int unsigned k;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, looping off, no idling on either side.
        write_loop(1'b0);
        send_item(tick_item(32'd5));                 // tick with nothing stored
        send_item(any_item(CMD_PLAY));               // play on an empty store
        send_item(frame_item(64'd100, '1, 1'b1, 4'hF, '1));   // length clamped
        send_item(frame_item(64'd105, '0, 1'b0, 4'h0, '0));
        send_item(frame_item(64'd108, 29'h0AAA_AAAA, 1'b0, MAX_LENGTH,
                             64'h0123_4567_89AB_CDEF));
        repeat (3) send_item(any_item(CMD_SPEED));    // up to 8x
        send_item(any_item(CMD_PLAY));
        send_item(tick_item(32'd0));                  // first frame is due at once
        send_item(tick_item(32'd1));                  // 8 us at 8x, end of store
        send_item(any_item(CMD_SPEED));               // 8x wraps to 1x
        send_item(any_item(CMD_PAUSE));
        send_item(any_item(CMD_REWIND));
        send_item(any_item(CMD_PLAY));
        send_item(tick_item('1));                     // widest delta
        send_item(frame_item(64'd3, 29'h1555_5555, 1'b1, 4'd9,
                             64'hFEDC_BA98_7654_3210)); // stamped before the first
        send_item(any_item(CMD_REWIND));
        send_item(any_item(CMD_PLAY));
        send_item(tick_item('1));                     // held back by the early stamp
        send_item(any_item(CMD_SPEED));
        send_item(any_item(CMD_STOP));                // speed back to 1x
        send_item(any_item(CMD_CLEAR));
        drain();

        // Looping on, sender idles often.
        write_loop(1'b1);
        set_idle(57, 0);
        random_phase(60);
        drain();

        // The receiver holds off for a long stretch while the sender keeps
        // offering items, so the block fills up and stops taking transfers.
        set_idle(0, 0);
        hold_req <= hold_req + 1;
        random_phase(30);
        drain();

        // Looping off, receiver stalls often.
        write_loop(1'b0);
        set_idle(0, 57);
        random_phase(60);
        drain();

        // Looping on, both sides idle.
        write_loop(1'b1);
        set_idle(29, 29);
        random_phase(60);
        drain();

        // A run of frames that are all due at once, so each tick is cut short
        // by the burst limit and the rest go out on the next tick.
        write_loop(1'b0);
        set_idle(0, 0);
        send_item(any_item(CMD_CLEAR));
        next_stamp = {$urandom, $urandom};
        for (k = 0; k < BURST_FILL; k++) begin
            send_item(frame_item(next_stamp, 29'($urandom), 1'($urandom),
                                 4'($urandom), {$urandom, $urandom}));
        end
        send_item(any_item(CMD_PLAY));
        repeat (2) send_item(tick_item(32'd0));
        drain();

        // The same frames with looping on, so replay wraps to the start.
        write_loop(1'b1);
        set_idle(29, 29);
        send_item(any_item(CMD_REWIND));
        send_item(any_item(CMD_PLAY));
        repeat (3) send_item(tick_item(32'd0));
        send_item(any_item(CMD_PAUSE));
        send_item(any_item(CMD_CLEAR));
        drain();

        $display("Covered %0d command items and %0d released frames over idle, stall,",
                 items_sent, frames_seen);
        $display("hold-off and burst-limit phases, with looping both on and off.");
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches found.", fail_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
